// ===== rtl/core/ring_chunk_timestamp_tracker_top_macros.svh =====
// Assertion helpers for the checker module.
`ifndef RING_CHUNK_TIMESTAMP_TRACKER_TOP_MACROS_SVH
`define RING_CHUNK_TIMESTAMP_TRACKER_TOP_MACROS_SVH

// clocked property, disabled while reset is asserted
`define RCTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked property, checked during reset too
`define RCTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rcts_pkg.sv =====
package rcts_pkg;

    localparam int STAMP_W = 64;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/rcts_if.sv =====
interface rcts_in_if #(
    parameter int INDEX_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             mode;
    logic [INDEX_BITS-1:0]  chunk_begin;
    logic [INDEX_BITS-1:0]  chunk_end;
    logic [63:0]            chunk_stamp;
    logic                   chunk_starts_frame;
    logic [INDEX_BITS-1:0]  read_position;

    modport source (
        output valid, mode, chunk_begin, chunk_end, chunk_stamp,
               chunk_starts_frame, read_position,
        input  ready
    );
    modport sink (
        input  valid, mode, chunk_begin, chunk_end, chunk_stamp,
               chunk_starts_frame, read_position,
        output ready
    );
endinterface

interface rcts_out_if #(
    parameter int CNT_BITS = 6
);
    logic                 valid;
    logic                 ready;
    logic [63:0]          frame_stamp;
    logic                 stamp_found;
    logic                 read_stalled;
    logic                 holder_found;
    logic [CNT_BITS-1:0]  chunks_removed;
    logic                 push_dropped;
    logic [CNT_BITS-1:0]  entries_held;

    modport source (
        output valid, frame_stamp, stamp_found, read_stalled, holder_found,
               chunks_removed, push_dropped, entries_held,
        input  ready
    );
    modport sink (
        input  valid, frame_stamp, stamp_found, read_stalled, holder_found,
               chunks_removed, push_dropped, entries_held,
        output ready
    );
endinterface

// ===== rtl/core/rcts_ram.sv =====
module rcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ring_chunk_timestamp_tracker_top.sv =====
// Channel   Dir  Modport  Payload
// i_item    in   sink     mode, chunk_begin/end, chunk_stamp, chunk_starts_frame, read_position
// o_result  out  source   frame_stamp, flags, chunks_removed, entries_held
//
// One transaction at a time. Push, clear and unused codes go from S_IDLE straight to S_OUT.
// Update pops chunks in S_EVAL, one pop per cycle through the chunk RAM's
// registered read port (address steered to the next head while popping).
// i_rst_n (sync, active low) empties the queue and forgets the previous read index.
// Input ready stays low until the result transaction completes.
module ring_chunk_timestamp_tracker_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int INDEX_BITS  = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcts_in_if.sink      i_item,
    rcts_out_if.source   o_result
);
    import rcts_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 2 * INDEX_BITS + STAMP_W + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    function automatic logic holds_index(input logic [INDEX_BITS-1:0] b,
                                         input logic [INDEX_BITS-1:0] e,
                                         input logic [INDEX_BITS-1:0] r);
        if (b < e) begin
            holds_index = (b < r) && (r <= e);
        end else begin
            holds_index = (b < r) || (r <= e);
        end
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_occ, n_occ;
    logic [INDEX_BITS-1:0] r_prev, n_prev;
    logic                  r_prev_valid, n_prev_valid;

    logic [INDEX_BITS-1:0] r_rd, n_rd;
    logic [STAMP_W-1:0]    r_stamp, n_stamp;
    logic                  r_found, n_found;
    logic                  r_stalled, n_stalled;
    logic                  r_holder, n_holder;
    logic [CW-1:0]         r_removed, n_removed;
    logic                  r_dropped, n_dropped;

    logic                  in_acc;
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_wdata, ram_rdata;
    logic [INDEX_BITS-1:0] rd_begin, rd_end;
    logic [STAMP_W-1:0]    rd_stamp;
    logic                  rd_flag;
    logic                  hold;
    logic [AW-1:0]         head_next;

    assign ram_wdata = {i_item.chunk_starts_frame, i_item.chunk_stamp,
                        i_item.chunk_end, i_item.chunk_begin};
    assign {rd_flag, rd_stamp, rd_end, rd_begin} = ram_rdata;

    rcts_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc    = i_item.valid && (r_state == S_IDLE);
    assign hold      = holds_index(rd_begin, rd_end, r_rd);
    assign head_next = next_slot(r_head);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_rd         = r_rd;
        n_stamp      = r_stamp;
        n_found      = r_found;
        n_stalled    = r_stalled;
        n_holder     = r_holder;
        n_removed    = r_removed;
        n_dropped    = r_dropped;
        ram_we       = 1'b0;
        ram_raddr    = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_stamp   = '0;
                    n_found   = 1'b0;
                    n_stalled = 1'b0;
                    n_holder  = 1'b0;
                    n_removed = '0;
                    n_dropped = 1'b0;
                    n_state   = S_OUT;
                    unique case (t_mode'(i_item.mode))
                        MODE_PUSH: begin
                            if (r_occ == FULL_CNT) begin
                                n_dropped = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                n_tail = next_slot(r_tail);
                                n_occ  = r_occ + CW'(1);
                            end
                        end
                        MODE_UPDATE: begin
                            n_rd         = i_item.read_position;
                            n_stalled    = r_prev_valid && (r_prev == i_item.read_position);
                            n_prev_valid = 1'b1;
                            n_prev       = i_item.read_position;
                            if (r_occ != '0) begin
                                n_state = S_EVAL;
                            end
                        end
                        MODE_CLEAR: begin
                            n_head = '0;
                            n_tail = '0;
                            n_occ  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EVAL: begin
                // RAM data is the head entry; prefetch the following one
                ram_raddr = head_next;
                if (!r_found && rd_flag) begin
                    n_stamp = rd_stamp;
                    n_found = 1'b1;
                end
                n_holder  = hold;
                n_head    = head_next;
                n_occ     = r_occ - CW'(1);
                n_removed = r_removed + CW'(1);
                if (hold || (r_occ == CW'(1))) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_occ        <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_occ        <= n_occ;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_stamp   <= n_stamp;
        r_found   <= n_found;
        r_stalled <= n_stalled;
        r_holder  <= n_holder;
        r_removed <= n_removed;
        r_dropped <= n_dropped;
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = (r_state == S_OUT);
    assign o_result.frame_stamp    = r_stamp;
    assign o_result.stamp_found    = r_found;
    assign o_result.read_stalled   = r_stalled;
    assign o_result.holder_found   = r_holder;
    assign o_result.chunks_removed = r_removed;
    assign o_result.push_dropped   = r_dropped;
    assign o_result.entries_held   = r_occ;
endmodule

// ===== rtl/core/rcts_chk.sv =====
`include "ring_chunk_timestamp_tracker_top_macros.svh"

module rcts_chk #(
    parameter int QUEUE_DEPTH = 32,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [63:0]   i_frame_stamp,
    input logic          i_stamp_found,
    input logic          i_holder_found,
    input logic [CW-1:0] i_chunks_removed,
    input logic          i_push_dropped,
    input logic [CW-1:0] i_entries_held
);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    `RCTS_ASSERT(a_out_hold, i_clk, i_rst_n,
                 i_out_valid && !i_out_ready |=> i_out_valid,
                 "result dropped while stalled")
    `RCTS_ASSERT(a_one_in_flight, i_clk, i_rst_n,
                 i_out_valid |-> !i_in_ready,
                 "input taken while result pending")
    `RCTS_ASSERT(a_occ_range, i_clk, i_rst_n,
                 i_out_valid |-> i_entries_held <= FULL_CNT,
                 "queue count beyond depth")
    `RCTS_ASSERT(a_drop_full, i_clk, i_rst_n,
                 i_out_valid && i_push_dropped |-> i_entries_held == FULL_CNT &&
                 i_chunks_removed == '0 && !i_holder_found,
                 "drop without full queue")
    `RCTS_ASSERT(a_stamp_zero, i_clk, i_rst_n,
                 i_out_valid && (!i_stamp_found || i_chunks_removed == '0) |->
                 i_frame_stamp == '0 || i_stamp_found,
                 "stamp without frame chunk")
endmodule

bind ring_chunk_timestamp_tracker_top rcts_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rcts_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_frame_stamp    (o_result.frame_stamp),
    .i_stamp_found    (o_result.stamp_found),
    .i_holder_found   (o_result.holder_found),
    .i_chunks_removed (o_result.chunks_removed),
    .i_push_dropped   (o_result.push_dropped),
    .i_entries_held   (o_result.entries_held)
);
